// ===== rtl/nbw_pkg.sv =====
// ----------------------------------------------------------------------------
// nbw_pkg
// Shared types, command codes and constants of the NAL bitstream writer.
// ----------------------------------------------------------------------------
package nbw_pkg;

   localparam int WORD_BITS = 32;
   localparam int MAX_NALS  = 128;

   localparam logic [2:0] CMD_BITS      = 3'd0;
   localparam logic [2:0] CMD_BITS_EOS  = 3'd1;
   localparam logic [2:0] CMD_UE        = 3'd2;
   localparam logic [2:0] CMD_SE        = 3'd3;
   localparam logic [2:0] CMD_TRAILING  = 3'd4;
   localparam logic [2:0] CMD_ALIGN     = 3'd5;
   localparam logic [2:0] CMD_STARTCODE = 3'd6;
   localparam logic [2:0] CMD_NONE      = 3'd7;

   localparam logic [7:0] EPB_BYTE   = 8'h03;
   localparam logic [7:0] SC_ONE     = 8'h01;
   localparam logic [7:0] ZERO_BYTE  = 8'h00;

   localparam logic [7:0] MAX_NALS_C = 8'(MAX_NALS);

   typedef struct packed {
      logic [2:0]  command;
      logic [31:0] code_value;
      logic [5:0]  code_length;
      logic [15:0] signed_value;
      logic        leading_zero;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       nal_start;
      logic       status;
      logic       last;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture request and plan
      logic emit;       // emit one pending byte
      logic finish;     // commit end-of-command state
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic pending;    // bytes still to emit after the current one
      logic drop;       // command dropped for overflow
   } sts_type;

endpackage

// ===== rtl/nbw_if.sv =====
// ----------------------------------------------------------------------------
// nbw_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface nbw_if #(parameter type T = logic);
   logic valid;
   logic ready;
   T     data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/nal_bitstream_writer_epb_unit.sv =====
// ----------------------------------------------------------------------------
// nal_bitstream_writer_epb_unit
// H.264 bitstream writer with Exp-Golomb coding and emulation prevention.
// ----------------------------------------------------------------------------
// Usage: send one command per transaction on the req channel. Each command
// returns one or more transactions on the rsp channel, one per stream byte
// (including inserted 0x03 bytes), the final one flagged by last. A command
// that emits no byte returns a single status-only transaction.
// Timing: a command is captured, planned in the next cycle, then emits
// one byte per cycle from the byte sequencer while the rsp register is
// free. One command is processed at a time; the next is taken once the
// last byte is queued. The rsp output register holds a byte while the
// receiver stalls and the sequencer waits. Reset empties the word, clears
// counters and sets max_stream_bytes to 16777215. Write max_stream_bytes
// at csr address 0 only while idle.
// ----------------------------------------------------------------------------
module nal_bitstream_writer_epb_unit
   import nbw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   nbw_if.sink         req,
   nbw_if.source       rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [0:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [23:0] max_ff;
   cmd_type     cmd;
   sts_type     sts;
   rsp_type     dp_rsp;
   logic        dp_load;
   logic        rvalid_ff;
   rsp_type     rdata_ff;
   logic        out_free;

   assign csr_pready = 1'b1;
   assign csr_prdata = {8'd0, max_ff};
   assign out_free   = !rvalid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= 24'hFF_FFFF;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 1'b0) begin
         max_ff <= csr_pwdata[23:0];
      end
   end

   nbw_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req.valid),
      .req_ready(req.ready),
      .out_free (out_free),
      .cmd      (cmd),
      .sts      (sts)
   );

   nbw_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .req      (req.data),
      .max_bytes(max_ff),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (dp_rsp),
      .rsp_load (dp_load)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rvalid_ff <= 1'b0;
      end else if (dp_load) begin
         rvalid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rvalid_ff <= 1'b0;
      end
      if (dp_load) rdata_ff <= dp_rsp;
   end

   assign rsp.valid = rvalid_ff;
   assign rsp.data  = rdata_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      dp_load |-> out_free) else $error("rsp register overwritten");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready) else $error("req taken while busy");
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.data.status) |-> rsp.data.last) else $error("status not last");

endmodule

// ===== rtl/nbw_ctrl.sv =====
// ----------------------------------------------------------------------------
// nbw_ctrl
// Controller: sequences capture, byte emission and commit of one command.
// ----------------------------------------------------------------------------
module nbw_ctrl
   import nbw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  logic    out_free,
   output cmd_type cmd,
   input  sts_type sts
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_PLAN = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      req_ready  = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_PLAN;
            end
         end
         S_PLAN: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               if (!sts.pending || sts.drop) begin
                  cmd.finish = 1'b1;
                  state_in   = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/nbw_datapath.sv =====
// ----------------------------------------------------------------------------
// nbw_datapath
// Bit packer, byte sequencer with emulation prevention and stream counters.
// ----------------------------------------------------------------------------
module nbw_datapath
   import nbw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  req_type     req,
   input  logic [23:0] max_bytes,
   input  cmd_type     cmd,
   output sts_type     sts,
   output rsp_type     rsp_data,
   output logic        rsp_load
);

   // captured request
   logic [2:0]  op_ff;
   logic [31:0] val_ff;
   logic [5:0]  len_ff;
   logic        lead_ff;

   // architectural state
   logic [31:0] word_ff, word_in;
   logic [6:0]  free_ff, free_in;
   logic [1:0]  zrun_ff, zrun_in;
   logic [23:0] offs_ff, offs_in;
   logic [7:0]  nals_ff, nals_in;

   // per-command plan
   logic [63:0] buf_ff;          // bytes to emit, MSB first
   logic [3:0]  cnt_ff;          // bytes still to emit
   logic        raw_ff;          // no emulation prevention
   logic        mark_ff;
   logic        drop_ff;
   logic        first_ff;
   logic [31:0] nword_ff;
   logic [6:0]  nfree_ff;
   logic [7:0]  nnals_ff;
   logic        zclr_ff;
   logic        stage_ff;

   // exp-golomb / length preparation from the request
   logic [16:0] eg_v;
   logic [4:0]  eg_z;
   logic [16:0] se_abs;
   logic signed [15:0] sv;
   logic [31:0] p_val;
   logic [5:0]  p_len;
   logic [5:0]  ln_c;

   always_comb begin
      sv     = req.signed_value;
      if (sv == -16'sd32768) sv = -16'sd32767;
      se_abs = '0;
      if (sv > 0) se_abs = 17'({sv[14:0], 1'b0}) - 17'd1;
      else        se_abs = {16'(-sv), 1'b0};
      if (req.command == CMD_UE)
         eg_v = (req.code_value > 32'd65534) ? 17'd65535 : 17'(req.code_value) + 17'd1;
      else
         eg_v = se_abs + 17'd1;
      eg_z = '0;
      for (int i = 1; i < 17; i++) begin
         if (eg_v[i]) eg_z = 5'(i);
      end
      ln_c = (req.code_length > 6'd32) ? 6'd32 : req.code_length;
      if (req.command == CMD_UE || req.command == CMD_SE) begin
         p_val = 32'(eg_v);
         p_len = 6'({eg_z, 1'b1});
      end else begin
         p_val = req.code_value;
         p_len = ln_c;
      end
   end

   // planning stage (the cycle after capture)
   logic [63:0] ext;          // value placed just below the bits held in word_ff, in a 64-bit window
   logic [63:0] comb_w;       // word_ff : ext merged
   logic [6:0]  pad;
   logic        ovf4;
   logic [2:0]  keep;
   logic [31:0] ones;

   always_comb begin
      ones   = (len_ff == 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << len_ff) - 32'd1);
      ext    = ({(val_ff & ones), 32'd0} << (7'd32 - {1'b0, len_ff})) >> (7'd32 - free_ff);
      comb_w = {word_ff, 32'd0} | ext;
      ovf4   = ({1'b0, offs_ff} + 25'd4) >= {1'b0, max_bytes};
      keep   = 3'((free_ff - 7'd1) >> 3);
      pad    = {4'd0, free_ff[2:0]};
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req.command;
         val_ff  <= p_val;
         len_ff  <= p_len;
         lead_ff <= req.leading_zero;
      end
   end

   logic [3:0]  plan_cnt;
   logic [63:0] plan_buf;
   logic        plan_raw, plan_mark, plan_drop, plan_zclr;
   logic [31:0] plan_word;
   logic [6:0]  plan_free;
   logic [7:0]  plan_nals;
   logic [6:0]  left;
   logic [63:0] al_w;
   logic [6:0]  al_free;

   always_comb begin
      plan_cnt  = '0;
      plan_buf  = '0;
      plan_raw  = 1'b0;
      plan_mark = 1'b0;
      plan_drop = 1'b0;
      plan_zclr = 1'b0;
      plan_word = word_ff;
      plan_free = free_ff;
      plan_nals = nals_ff;
      left      = free_ff - {1'b0, len_ff};
      al_w      = {word_ff | (~(32'hFFFF_FFFF << pad) << (free_ff - pad)), 32'd0};
      if (pad == 7'd0) al_w = {word_ff, 32'd0};
      al_free   = free_ff - pad;
      case (op_ff)
         CMD_BITS, CMD_UE, CMD_SE: begin
            if (free_ff > {1'b0, len_ff}) begin
               plan_word = comb_w[63:32];
               plan_free = left;
            end else if (ovf4) begin
               plan_drop = 1'b1;
            end else begin
               plan_cnt  = 4'd4;
               plan_buf  = comb_w;
               plan_word = comb_w[31:0];
               plan_free = 7'd32 + left;
            end
         end
         CMD_BITS_EOS: begin
            if (ovf4) plan_drop = 1'b1;
            else begin
               plan_buf  = comb_w;
               plan_cnt  = (free_ff >= {1'b0, len_ff}) ? 4'd4 : 4'd8;
               plan_word = '0;
               plan_free = 7'd32;
            end
         end
         CMD_TRAILING: begin
            if (({1'b0, offs_ff} + 25'd4 - 25'(keep)) >= {1'b0, max_bytes})
               plan_drop = 1'b1;
            else begin
               plan_buf  = {word_ff | (32'd1 << (free_ff - 7'd1)), 32'd0};
               plan_cnt  = 4'd4 - 4'(keep);
               plan_word = '0;
               plan_free = 7'd32;
               plan_zclr = 1'b1;
            end
         end
         CMD_ALIGN: begin
            if (pad != 7'd0 && al_free == 7'd0 && ovf4) plan_drop = 1'b1;
            else if (al_free == 7'd0) begin
               plan_buf  = al_w;
               plan_cnt  = 4'd4;
               plan_word = '0;
               plan_free = 7'd32;
            end else if (al_free != 7'd32) begin
               plan_buf  = al_w;
               plan_cnt  = 4'd4 - 4'(al_free >> 3);
               plan_word = '0;
               plan_free = 7'd32;
               plan_zclr = 1'b1;
            end
         end
         CMD_STARTCODE: begin
            if (ovf4) plan_drop = 1'b1;
            else begin
               plan_raw  = 1'b1;
               plan_mark = (nals_ff < MAX_NALS_C);
               if (plan_mark) plan_nals = nals_ff + 8'd1;
               plan_cnt  = lead_ff ? 4'd4 : 4'd3;
               plan_buf  = lead_ff ? {ZERO_BYTE, ZERO_BYTE, ZERO_BYTE, SC_ONE, 32'd0} :
                                     {ZERO_BYTE, ZERO_BYTE, SC_ONE, 40'd0};
            end
         end
         default: ;
      endcase
   end

   // emission
   logic [7:0] cur;
   logic       ins;
   logic       last_b;

   always_comb begin
      cur     = buf_ff[63:56];
      ins     = !raw_ff && zrun_ff >= 2'd2 && cur <= EPB_BYTE && cnt_ff != 4'd0;
      last_b  = (cnt_ff <= 4'd1) && !ins;
      rsp_data = '0;
      rsp_data.last = 1'b1;
      sts.drop    = drop_ff;
      sts.pending = (cnt_ff > 4'd1) || ins;
      if (drop_ff) begin
         rsp_data.status = 1'b1;
      end else if (cnt_ff != 4'd0) begin
         rsp_data.byte_valid = 1'b1;
         rsp_data.out_byte   = ins ? EPB_BYTE : cur;
         rsp_data.nal_start  = mark_ff && first_ff && !ins;
         rsp_data.last       = last_b;
      end
      rsp_load = cmd.emit && stage_ff;
   end

   always_comb begin
      word_in = word_ff; free_in = free_ff; zrun_in = zrun_ff;
      offs_in = offs_ff; nals_in = nals_ff;
      if (cmd.emit && stage_ff && cnt_ff != 4'd0 && !drop_ff) begin
         offs_in = offs_ff + 24'd1;
         if (ins) zrun_in = '0;
         else if (!raw_ff) zrun_in = (cur == ZERO_BYTE) ? zrun_ff + 2'd1 : 2'd0;
      end
      if (cmd.finish && !drop_ff) begin
         word_in = nword_ff;
         free_in = nfree_ff;
         nals_in = nnals_ff;
         if (zclr_ff) zrun_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 1'b1;
         word_ff  <= '0;
         free_ff  <= 7'd32;
         zrun_ff  <= '0;
         offs_ff  <= '0;
         nals_ff  <= '0;
      end else begin
         word_ff <= word_in;
         free_ff <= free_in;
         zrun_ff <= zrun_in;
         offs_ff <= offs_in;
         nals_ff <= nals_in;
         if (cmd.load) stage_ff <= 1'b0;
         else if (!stage_ff) begin
            stage_ff <= 1'b1;
            buf_ff   <= plan_buf;
            cnt_ff   <= plan_cnt;
            raw_ff   <= plan_raw;
            mark_ff  <= plan_mark;
            drop_ff  <= plan_drop;
            nword_ff <= plan_word;
            nfree_ff <= plan_free;
            nnals_ff <= plan_nals;
            zclr_ff  <= plan_zclr;
            first_ff <= 1'b1;
         end else if (cmd.emit && cnt_ff != 4'd0 && !drop_ff) begin
            first_ff <= 1'b0;
            if (!ins) begin
               buf_ff <= buf_ff << 8;
               cnt_ff <= cnt_ff - 4'd1;
            end
         end
      end
   end

endmodule

// ===== tb/nal_bitstream_writer_epb_unit_tb.sv =====
// ----------------------------------------------------------------------------
// nal_bitstream_writer_epb_unit_tb
// Self-checking bench for the NAL bitstream writer. A directed table and a
// random phase of commands drive the req channel in bursts; every rsp
// transaction is checked against a local model of the bit packer, the
// emulation prevention and the overflow checks, under several stream sizes.
// ----------------------------------------------------------------------------
module nal_bitstream_writer_epb_unit_tb;
   import nbw_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [0:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   nbw_if #(.T(req_type)) req_ch ();
   nbw_if #(.T(rsp_type)) rsp_ch ();

   nal_bitstream_writer_epb_unit i_dut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #4 clock = ~clock;

   initial begin
      #8000000;
      $display("nal_bitstream_writer_epb_unit_tb: done, errors");
      $finish;
   end

   // writer model state
   logic [23:0] m_size;
   logic [31:0] m_word;
   int unsigned m_free;
   int unsigned m_zeros;
   logic [23:0] m_offset;
   int unsigned m_nals;

   rsp_type     byte_queue[$];
   int unsigned built;
   int          mismatches = 0;

   typedef struct {
      req_type item;
      bit      typed;
      rsp_type first_rsp;
   } row_type;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      rsp_ch.ready = 1'b0;
   end

   function automatic void model_reset();
      m_size = 24'hFFFFFF; m_word = '0; m_free = 32;
      m_zeros = 0; m_offset = '0; m_nals = 0;
   endfunction

   function automatic void push_byte(logic [7:0] b, logic mark);
      rsp_type r;
      r = '{out_byte: b, byte_valid: 1'b1, nal_start: mark, status: 1'b0, last: 1'b0};
      byte_queue.push_back(r);
      built++;
      m_offset = m_offset + 24'd1;
   endfunction

   function automatic void push_escaped(logic [7:0] b);
      if (m_zeros >= 2 && b <= 8'h03) begin
         push_byte(EPB_BYTE, 1'b0);
         m_zeros = 0;
      end
      push_byte(b, 1'b0);
      m_zeros = (b == 8'h00) ? ((m_zeros + 1) & 3) : 0;
   endfunction

   function automatic void flush_top(logic [31:0] w, int unsigned stop);
      for (int unsigned i = 32; i > stop; i -= 8)
         push_escaped(w[i-1 -: 8]);
   endfunction

   function automatic bit full_by(int unsigned extra);
      return (32'(m_offset) + extra) >= 32'(m_size);
   endfunction

   function automatic logic [31:0] ones(int unsigned n);
      return 32'((64'd1 << n) - 64'd1);
   endfunction

   function automatic bit pack_bits(logic [31:0] v, int unsigned len, bit eos);
      int unsigned rest;
      logic [63:0] wide;
      if (len > 32) len = 32;
      v &= ones(len);
      wide = 64'(v);
      if (!eos) begin
         if (m_free > len) begin
            m_free -= len;
            m_word |= 32'(wide << m_free);
            return 1;
         end
         if (full_by(4)) return 0;
         rest = len - m_free;
         m_word |= v >> rest;
         flush_top(m_word, 0);
         m_word = rest ? 32'(wide << (32 - rest)) : '0;
         m_free = 32 - rest;
         return 1;
      end
      if (full_by(4)) return 0;
      if (len < m_free) begin
         m_word |= 32'(wide << (m_free - len));
         rest = 0;
      end else begin
         rest = len - m_free;
         m_word |= v >> rest;
      end
      flush_top(m_word, 0);
      if (rest) flush_top((v & ones(rest)) << (32 - rest), 0);
      m_word = '0; m_free = 32;
      return 1;
   endfunction

   function automatic bit pack_golomb(logic [31:0] num);
      logic [31:0] v;
      int unsigned nz;
      v = num + 1; nz = 0;
      while ((v >> (nz + 1)) != 0) nz++;
      return pack_bits(v, 2 * nz + 1, 0);
   endfunction

   function automatic void clear_word();
      m_word = '0; m_free = 32; m_zeros = 0;
   endfunction

   // append the expected rsp transactions of one command
   function automatic void predict_bytes(req_type t);
      bit ok;
      int s;
      int unsigned keep, pad;
      logic mark;
      rsp_type r;
      ok = 1; built = 0;
      case (t.command)
         CMD_BITS:     ok = pack_bits(t.code_value, t.code_length, 0);
         CMD_BITS_EOS: ok = pack_bits(t.code_value, t.code_length, 1);
         CMD_UE: ok = pack_golomb(t.code_value > 65534 ? 32'd65534 : t.code_value);
         CMD_SE: begin
            s = $signed(t.signed_value);
            if (s < -32767) s = -32767;
            ok = pack_golomb(s > 0 ? 32'(2 * s - 1) : 32'(-2 * s));
         end
         CMD_TRAILING: begin
            keep = (m_free - 1) >> 3;
            if (full_by(4 - keep)) ok = 0;
            else begin
               m_word |= 32'd1 << (m_free - 1);
               flush_top(m_word, keep * 8);
               clear_word();
            end
         end
         CMD_ALIGN: begin
            pad = m_free & 7;
            if (pad) ok = pack_bits(ones(pad), pad, 0);
            if (ok && m_free != 0 && m_free != 32) begin
               flush_top(m_word, (m_free >> 3) * 8);
               clear_word();
            end
         end
         CMD_STARTCODE: begin
            if (full_by(4)) ok = 0;
            else begin
               mark = 1'b0;
               if (m_nals < MAX_NALS) begin
                  m_nals = (m_nals + 1) & 8'hFF;
                  mark = 1'b1;
               end
               if (t.leading_zero) begin
                  push_byte(ZERO_BYTE, mark);
                  mark = 1'b0;
               end
               push_byte(ZERO_BYTE, mark);
               push_byte(ZERO_BYTE, 1'b0);
               push_byte(SC_ONE, 1'b0);
            end
         end
         default: ;
      endcase
      if (built == 0) begin
         r = '{out_byte: 8'h00, byte_valid: 1'b0, nal_start: 1'b0, status: !ok, last: 1'b1};
         byte_queue.push_back(r);
      end else begin
         r = byte_queue.pop_back();
         r.last = 1'b1;
         byte_queue.push_back(r);
      end
   endfunction

   // receiver: stall pattern plus check
   int unsigned rx_phase = 0;
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         rx_phase <= rx_phase + 1;
         rsp_ch.ready <= (rx_phase[8:6] == 3'd5) ? 1'b1 :
                         ($urandom_range(0, 3) != 0 || rx_phase[5]);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (byte_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected rsp transaction %p", rsp_ch.data);
            end else begin
               want = byte_queue.pop_front();
               if (rsp_ch.data !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("rsp mismatch: expected %p, got %p", want, rsp_ch.data);
               end
            end
         end
      end
   end

   task automatic csr_write(logic [23:0] value);
      @(posedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= '0; csr_pwdata <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      m_size = value;
   endtask

   int unsigned burst_left = 0;

   task automatic drain();
      if (burst_left != 0) req_ch.valid <= 1'b0;
      burst_left = 0;
      while (byte_queue.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic send(req_type t, bit typed = 1'b0, rsp_type first_rsp = '0);
      int unsigned base;
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 5)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.data  <= t;
      base = byte_queue.size();
      predict_bytes(t);
      if (typed) byte_queue[base] = first_rsp;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (burst_left == 0) req_ch.valid <= 1'b0;
   endtask

   function automatic req_type make(logic [2:0] c, logic [31:0] v, logic [5:0] n,
                                    logic [15:0] s, logic z);
      return '{command: c, code_value: v, code_length: n, signed_value: s,
               leading_zero: z};
   endfunction

   function automatic row_type row(req_type t);
      return '{item: t, typed: 1'b0, first_rsp: '0};
   endfunction

   function automatic row_type row_want(req_type t, rsp_type w);
      return '{item: t, typed: 1'b1, first_rsp: w};
   endfunction

   function automatic req_type rand_item();
      req_type t;
      int unsigned pick;
      t = '{command: 3'($urandom_range(0, 7)), code_value: $urandom(),
            code_length: 6'($urandom()), signed_value: 16'($urandom()),
            leading_zero: 1'($urandom())};
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
         t.command = pick[0] ? CMD_UE : CMD_BITS;
         t.code_value = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 300);
         t.code_length = 6'($urandom_range(1, 32));
      end else if (pick == 4) begin
         t.command = CMD_SE;
      end
      if ($urandom_range(0, 7) == 0) t.code_value = 32'h0;
      return t;
   endfunction

   row_type table_rows[$];

   initial begin
      model_reset();
      table_rows = '{
         row_want(make(CMD_ALIGN,     0, 0, 0, 0),
                  rsp_type'{8'h00, 1'b0, 1'b0, 1'b0, 1'b1}),
         row_want(make(CMD_TRAILING,  0, 0, 0, 0),
                  rsp_type'{8'h80, 1'b1, 1'b0, 1'b0, 1'b1}),
         row_want(make(CMD_STARTCODE, 0, 0, 0, 1),
                  rsp_type'{8'h00, 1'b1, 1'b1, 1'b0, 1'b0}),
         row_want(make(CMD_STARTCODE, 0, 0, 0, 0),
                  rsp_type'{8'h00, 1'b1, 1'b1, 1'b0, 1'b0}),
         row_want(make(CMD_BITS,      32'hFFFF_FFFF, 6'd32, 0, 0),
                  rsp_type'{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0}),
         row(make(CMD_BITS,      32'h0, 6'd32, 0, 0)),
         row(make(CMD_BITS,      32'h0000_0102, 6'd32, 0, 0)),
         row(make(CMD_BITS,      32'hFFFF_FFFF, 6'd63, 0, 0)),
         row(make(CMD_BITS,      32'hFFFF_FFFF, 6'd0, 0, 0)),
         row(make(CMD_BITS_EOS,  32'h0, 6'd0, 0, 0)),
         row(make(CMD_BITS,      32'h5, 6'd3, 0, 0)),
         row(make(CMD_BITS_EOS,  32'hABCD_1234, 6'd32, 0, 0)),
         row(make(CMD_UE,        32'd0, 0, 0, 0)),
         row(make(CMD_UE,        32'hFFFF_FFFF, 0, 0, 0)),
         row(make(CMD_UE,        32'd65534, 0, 0, 0)),
         row(make(CMD_SE,        0, 0, 16'h8000, 0)),
         row(make(CMD_SE,        0, 0, 16'h7FFF, 0)),
         row(make(CMD_SE,        0, 0, 16'h0000, 0)),
         row(make(CMD_SE,        0, 0, 16'hFFFF, 0)),
         row(make(CMD_ALIGN,     0, 0, 0, 0)),
         row(make(CMD_BITS,      32'h1, 6'd5, 0, 0)),
         row(make(CMD_TRAILING,  0, 0, 0, 0)),
         row_want(make(CMD_NONE, 32'hFFFF_FFFF, 6'd63, 16'hFFFF, 1),
                  rsp_type'{8'h00, 1'b0, 1'b0, 1'b0, 1'b1})
      };
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (table_rows[i])
         send(table_rows[i].item, table_rows[i].typed, table_rows[i].first_rsp);
      drain();
      // tiny buffer: overflow
      csr_write(24'd0);
      for (int i = 0; i < 20; i++) send(rand_item());
      drain();
      csr_write(24'd40);
      for (int i = 0; i < 40; i++) send(rand_item());
      drain();
      csr_write(24'(32'(m_offset) + 60));
      for (int i = 0; i < 60; i++) send(rand_item());
      drain();
      csr_write(24'hFFFFFF);
      for (int i = 0; i < 40; i++) begin
         if (i == 20) drain();
         send(rand_item());
      end
      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && byte_queue.size() == 0)
         $display("nal_bitstream_writer_epb_unit_tb: done, clean");
      else
         $display("nal_bitstream_writer_epb_unit_tb: done, errors");
      $finish;
   end

endmodule
